[rtl/core/thp_sensor_compensation_defines.svh]
// assertion macros shared by the compensation rtl
`ifndef THP_SENSOR_COMPENSATION_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication, reset masked
`define THP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define THP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/thp_pkg.sv]
// shared types and constants of the compensation pipeline
package thp_pkg;

    localparam int TF_LAT     = 3;
    localparam int TEMP_LAT   = 4;
    localparam int HUM_LAT    = 8;
    localparam int DIV_STAGES = 64;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int PRE_LAT    = 6;
    localparam int POST_LAT   = 6;
    localparam int PRES_LAT   = PRE_LAT + DIV_LAT + POST_LAT;
    localparam int TOTAL_LAT  = TF_LAT + PRES_LAT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_L = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM    = 3'd4;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } thp_coef_t;

endpackage

[rtl/core/thp_div.sv]
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
module thp_div
    import thp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    logic [63:0] rem_reg [DIV_STAGES+1];
    logic [63:0] nq_reg  [DIV_STAGES+1];
    logic [63:0] md_reg  [DIV_STAGES+1];
    logic        neg_reg [DIV_STAGES+1];
    logic [63:0] quo_reg;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num[63] ? (64'd0 - num) : num;
            md_reg[0]  <= den[63] ? (64'd0 - den) : den;
            neg_reg[0] <= num[63] ^ den[63];
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [64:0] trial;
        logic [64:0] diff;

        assign trial = {rem_reg[k], nq_reg[k][63]};
        assign diff  = trial - {1'b0, md_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[64])
                begin
                    rem_reg[k+1] <= diff[63:0];
                    nq_reg[k+1]  <= {nq_reg[k][62:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= trial[63:0];
                    nq_reg[k+1]  <= {nq_reg[k][62:0], 1'b0};
                end
                md_reg[k+1]  <= md_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[DIV_STAGES] ? (64'd0 - nq_reg[DIV_STAGES]) : nq_reg[DIV_STAGES];
        end
    end

    assign quo = quo_reg;

endmodule

[rtl/core/thp_pres.sv]
// pressure path: 64-bit pre-division terms, divider and post-division correction
module thp_pres
    import thp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic      [31:0] tf,
    input  logic      [19:0] raw_pressure,
    input  thp_coef_t        coef,
    output logic      [31:0] pressure_fixed,
    output logic             pressure_valid
);

    localparam logic signed [32:0] TF_OFFSET = 33'sd128000;
    localparam logic [20:0]        P_FULL    = 21'd1048576;
    localparam logic [63:0]        P_SCALE   = 64'd3125;
    localparam logic [63:0]        P_BIAS    = 64'd1 << 47;

    logic signed [63:0] p3_x, p4_x, p6_x, p7_x, p8_x, p9_x;

    assign p3_x = 64'(coef.p3);
    assign p4_x = 64'(coef.p4);
    assign p6_x = 64'(coef.p6);
    assign p7_x = 64'(coef.p7);
    assign p8_x = 64'(coef.p8);
    assign p9_x = 64'(coef.p9);

    // stage 1
    logic signed [32:0] v1_reg;
    logic        [19:0] rp1_reg;
    // stage 2
    logic signed [65:0] sq_full;
    logic signed [48:0] q5_full, q2_full;
    logic signed [63:0] sq_reg;
    logic signed [48:0] q5_reg, q2_reg;
    logic        [19:0] rp2_reg;
    // stage 3
    logic signed [63:0] s6_reg, s3_reg, c5_reg, c2_reg;
    logic        [19:0] rp3_reg;
    // stage 4
    logic signed [63:0] v2_reg, v1b_reg;
    logic        [19:0] rp4_reg;
    // stage 5
    logic        [63:0] v1c_reg, n_reg;
    // stage 6
    logic        [63:0] den_reg, num_reg;
    logic               vld_reg;
    logic signed [63:0] den_sh;

    assign sq_full = v1_reg * v1_reg;
    assign q5_full = v1_reg * 49'(coef.p5);
    assign q2_full = v1_reg * 49'(coef.p2);
    assign den_sh  = $signed(v1c_reg) >>> 33;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg  <= $signed({tf[31], tf}) - TF_OFFSET;
            rp1_reg <= raw_pressure;

            sq_reg  <= sq_full[63:0];
            q5_reg  <= q5_full;
            q2_reg  <= q2_full;
            rp2_reg <= rp1_reg;

            s6_reg  <= sq_reg * p6_x;
            s3_reg  <= sq_reg * p3_x;
            c5_reg  <= (64'(q5_reg) <<< 17) + (p4_x <<< 35);
            c2_reg  <= 64'(q2_reg) <<< 12;
            rp3_reg <= rp2_reg;

            v2_reg  <= s6_reg + c5_reg;
            v1b_reg <= (s3_reg >>> 8) + c2_reg;
            rp4_reg <= rp3_reg;

            v1c_reg <= (P_BIAS + v1b_reg) * {48'd0, coef.p1};
            n_reg   <= ({43'd0, P_FULL - {1'b0, rp4_reg}} << 31) - v2_reg;

            den_reg <= den_sh;
            num_reg <= n_reg * P_SCALE;
            vld_reg <= (den_sh != 64'sd0);
        end
    end

    logic [63:0] quo;

    thp_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // divisor-nonzero flag kept in step with the quotient
    logic vq_dly [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vq_dly[0] <= vld_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vq_dly[i] <= vq_dly[i-1];
            end
        end
    end

    // post-division correction
    logic signed [63:0] q0_reg, x0_reg;
    logic signed [63:0] q1_reg, x1_reg, a9_reg;
    logic signed [63:0] q2p_reg, f0_reg;
    logic        [63:0] ll_reg;
    logic        [31:0] lh_reg, hl_reg;
    logic signed [63:0] q3_reg, prod_reg, f_reg;
    logic signed [63:0] s_reg;
    logic        [31:0] out_reg;
    logic               vq0_reg, vq1_reg, vq2_reg, vq3_reg, vq4_reg, pv_reg;
    logic signed [63:0] pres_sum;

    assign pres_sum = (s_reg >>> 8) + (p7_x <<< 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg  <= quo;
            x0_reg  <= $signed(quo) >>> 13;
            vq0_reg <= vq_dly[DIV_LAT-1];

            q1_reg  <= q0_reg;
            x1_reg  <= x0_reg;
            a9_reg  <= x0_reg * p9_x;
            vq1_reg <= vq0_reg;

            // low 64 bits of a 64 by 64 product from 32-bit partial products
            ll_reg  <= {32'd0, a9_reg[31:0]} * {32'd0, x1_reg[31:0]};
            lh_reg  <= 32'(a9_reg[31:0] * x1_reg[63:32]);
            hl_reg  <= 32'(a9_reg[63:32] * x1_reg[31:0]);
            f0_reg  <= q1_reg * p8_x;
            q2p_reg <= q1_reg;
            vq2_reg <= vq1_reg;

            prod_reg <= $signed(ll_reg + {lh_reg + hl_reg, 32'd0});
            f_reg    <= f0_reg >>> 19;
            q3_reg   <= q2p_reg;
            vq3_reg  <= vq2_reg;

            s_reg   <= q3_reg + (prod_reg >>> 25) + f_reg;
            vq4_reg <= vq3_reg;

            out_reg <= vq4_reg ? pres_sum[31:0] : 32'd0;
            pv_reg  <= vq4_reg;
        end
    end

    assign pressure_fixed = out_reg;
    assign pressure_valid = pv_reg;

endmodule

[rtl/core/thp_temp.sv]
// temperature path: fine temperature and hundredths of a degree
module thp_temp
    import thp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic      [19:0] raw_temperature,
    input  thp_coef_t        coef,
    output logic      [31:0] tf,
    output logic      [17:0] temperature_centi
);

    logic [31:0] t1_x, t2_x, t3_x;

    assign t1_x = {16'd0, coef.t1};
    assign t2_x = 32'(coef.t2);
    assign t3_x = 32'(coef.t3);

    logic [31:0] pa_reg, d_reg;
    logic [31:0] m1_reg, m2_reg;
    logic [31:0] tf_reg;
    logic [17:0] temp_reg;
    logic [31:0] m2_sh, m3, tf5;

    assign m2_sh = $signed(m2_reg) >>> 12;
    assign m3    = m2_sh * t3_x;
    assign tf5   = (tf_reg * 32'd5) + 32'd128;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= {15'd0, raw_temperature[19:3]} - {t1_x[30:0], 1'b0};
            d_reg  <= {16'd0, raw_temperature[19:4]} - t1_x;

            m1_reg <= pa_reg * t2_x;
            m2_reg <= d_reg * d_reg;

            tf_reg <= 32'($signed(m1_reg) >>> 11) + 32'($signed(m3) >>> 14);

            temp_reg <= 18'($signed(tf5) >>> 8);
        end
    end

    assign tf                = tf_reg;
    assign temperature_centi = temp_reg;

endmodule

[rtl/core/thp_hum.sv]
// humidity path: 32-bit compensation with clamp to 100 percent
module thp_hum
    import thp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic      [31:0] tf,
    input  logic      [15:0] raw_humidity,
    input  thp_coef_t        coef,
    output logic      [16:0] humidity_fixed
);

    localparam logic [31:0] TF_REF   = 32'd76800;
    localparam logic [31:0] H_MAX    = 32'd419430400;
    localparam logic [31:0] Y_OFFSET = 32'd2097152;

    logic [31:0] h1_x, h2_x, h3_x, h4_x, h5_x, h6_x;

    assign h1_x = {24'd0, coef.h1};
    assign h2_x = 32'(coef.h2);
    assign h3_x = {24'd0, coef.h3};
    assign h4_x = 32'(coef.h4);
    assign h5_x = 32'(coef.h5);
    assign h6_x = 32'(coef.h6);

    logic [31:0] v_reg;
    logic [15:0] rh_reg;
    logic [31:0] x0_reg, m6_reg, m3_reg;
    logic [31:0] x2_reg, y0_reg;
    logic [31:0] x3_reg, y2_reg;
    logic [31:0] vv4_reg;
    logic [31:0] vv5_reg, ss_reg;
    logic [31:0] vv6_reg, t_reg;
    logic [16:0] out_reg;

    logic [31:0] y1, s5, w;

    assign y1 = 32'($signed(y0_reg) >>> 10) + Y_OFFSET;
    assign s5 = $signed(vv4_reg) >>> 15;
    assign w  = vv6_reg - 32'($signed(t_reg) >>> 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg  <= tf - TF_REF;
            rh_reg <= raw_humidity;

            x0_reg <= ({16'd0, rh_reg} << 14) - (h4_x << 20) - (h5_x * v_reg) + 32'd16384;
            m6_reg <= v_reg * h6_x;
            m3_reg <= v_reg * h3_x;

            x2_reg <= $signed(x0_reg) >>> 15;
            y0_reg <= 32'($signed(m6_reg) >>> 10) * (32'($signed(m3_reg) >>> 11) + 32'd32768);

            x3_reg <= x2_reg;
            y2_reg <= (y1 * h2_x) + 32'd8192;

            vv4_reg <= x3_reg * 32'($signed(y2_reg) >>> 14);

            vv5_reg <= vv4_reg;
            ss_reg  <= s5 * s5;

            vv6_reg <= vv5_reg;
            t_reg   <= 32'($signed(ss_reg) >>> 7) * h1_x;

            // negative reads as zero, above full scale saturates
            if (w[31])
            begin
                out_reg <= '0;
            end
            else if (w > H_MAX)
            begin
                out_reg <= H_MAX[28:12];
            end
            else
            begin
                out_reg <= w[28:12];
            end
        end
    end

    assign humidity_fixed = out_reg;

endmodule

[rtl/core/thp_sensor_compensation.sv]
// Temperature, pressure and humidity compensation of one raw triple per
// transfer. A new triple is taken every cycle unless the result side holds
// off; depth comes from the 64-stage pressure divider (one quotient bit per
// stage) plus the multiply stages around it. On hold-off the whole pipeline
// halts in place and s_axis_tready drops; nothing is dropped or repeated.
// Coefficients reset to zero; the user must write them through the cfg port
// only while no triple is in flight, which the block does not enforce.
module thp_sensor_compensation
    import thp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
    input  logic [55:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // temperature_centi [17:0], pressure_fixed [49:18], humidity_fixed [66:50]
    output logic [71:0]           m_axis_tdata,
    // pressure_valid [0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "thp_sensor_compensation_defines.svh"

    localparam int TEMP_DLY = TOTAL_LAT - TEMP_LAT;
    localparam int HUM_DLY  = PRES_LAT - HUM_LAT;

    logic [47:0] r0_reg;
    logic [63:0] r1_reg, r2_reg;
    logic [47:0] r3_reg;
    logic [31:0] r4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg <= '0;
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
            r4_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP:   r0_reg <= cfg_data[47:0];
                REG_PRES_L: r1_reg <= cfg_data;
                REG_PRES_H: r2_reg <= cfg_data;
                REG_MIXED:  r3_reg <= cfg_data[47:0];
                REG_HUM:    r4_reg <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    thp_coef_t coef;

    always_comb
    begin
        coef.t1 = r0_reg[15:0];
        coef.t2 = r0_reg[31:16];
        coef.t3 = r0_reg[47:32];
        coef.p1 = r1_reg[15:0];
        coef.p2 = r1_reg[31:16];
        coef.p3 = r1_reg[47:32];
        coef.p4 = r1_reg[63:48];
        coef.p5 = r2_reg[15:0];
        coef.p6 = r2_reg[31:16];
        coef.p7 = r2_reg[47:32];
        coef.p8 = r2_reg[63:48];
        coef.p9 = r3_reg[15:0];
        coef.h1 = r3_reg[23:16];
        coef.h2 = r3_reg[39:24];
        coef.h3 = r3_reg[47:40];
        coef.h4 = r4_reg[11:0];
        coef.h5 = r4_reg[23:12];
        coef.h6 = r4_reg[31:24];
    end

    // whole pipeline moves together; holds while the output waits
    logic adv;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic vld_reg [TOTAL_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[TOTAL_LAT-1];
        end
    end

    logic [31:0] tf;
    logic [17:0] temp_centi;
    logic [31:0] pres_fixed;
    logic        pres_valid;
    logic [16:0] hum_fixed;

    thp_temp u_temp (
        .clk               (clk),
        .en                (adv),
        .raw_temperature   (s_axis_tdata[19:0]),
        .coef              (coef),
        .tf                (tf),
        .temperature_centi (temp_centi)
    );

    logic [19:0] rp_dly [TF_LAT];
    logic [15:0] rh_dly [TF_LAT];
    logic [17:0] temp_dly [TEMP_DLY];
    logic [16:0] hum_dly [HUM_DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_dly[0]   <= s_axis_tdata[39:20];
            rh_dly[0]   <= s_axis_tdata[55:40];
            temp_dly[0] <= temp_centi;
            hum_dly[0]  <= hum_fixed;
            for (int i = 1; i < TF_LAT; i++)
            begin
                rp_dly[i] <= rp_dly[i-1];
                rh_dly[i] <= rh_dly[i-1];
            end
            for (int i = 1; i < TEMP_DLY; i++)
            begin
                temp_dly[i] <= temp_dly[i-1];
            end
            for (int i = 1; i < HUM_DLY; i++)
            begin
                hum_dly[i] <= hum_dly[i-1];
            end
        end
    end

    thp_pres u_pres (
        .clk            (clk),
        .en             (adv),
        .tf             (tf),
        .raw_pressure   (rp_dly[TF_LAT-1]),
        .coef           (coef),
        .pressure_fixed (pres_fixed),
        .pressure_valid (pres_valid)
    );

    thp_hum u_hum (
        .clk            (clk),
        .en             (adv),
        .tf             (tf),
        .raw_humidity   (rh_dly[TF_LAT-1]),
        .coef           (coef),
        .humidity_fixed (hum_fixed)
    );

    logic [71:0] out_data_reg;
    logic        out_user_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {5'd0, hum_dly[HUM_DLY-1], pres_fixed, temp_dly[TEMP_DLY-1]};
            out_user_reg <= pres_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `THP_ASSERT_NOW(a_pres_zero_when_invalid, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[49:18] == 32'd0, "pressure not zero with divisor zero")
    `THP_ASSERT_NOW(a_hum_clamped, m_axis_tvalid, m_axis_tdata[66:50] <= 17'd102400, "humidity above full scale")
    `THP_ASSERT_NEXT(a_stall_keeps_last, vld_reg[TOTAL_LAT-1] && !adv, vld_reg[TOTAL_LAT-1], "item lost in stalled pipeline")

endmodule
